// ===== src/mufb_pkg.sv =====
// ----------------------------------------------------------------------------
// mufb_pkg
// Types, codes and sizes shared by the uniform fit-to-box block.
// ----------------------------------------------------------------------------
`default_nettype none

package mufb_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int FRAC_BITS    = 16;

	localparam int COORD_W = 32;
	localparam int IDX_W   = $clog2(MAX_VERTICES);
	localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
	localparam int SCALE_W = 48;
	localparam int SPLIT   = 24;
	localparam int DIVN_W  = COORD_W + FRAC_BITS;
	localparam int DCNT_W  = $clog2(DIVN_W);

	localparam logic [63:0] SCALE_MAX = 64'h0000_7FFF_FFFF_FFFF;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX  = 2'd2;
	localparam logic [1:0] ST_DEGENERATE = 2'd3;

	localparam logic [2:0] REG_BOX_LEFT   = 3'd0;
	localparam logic [2:0] REG_BOX_RIGHT  = 3'd1;
	localparam logic [2:0] REG_BOX_BOTTOM = 3'd2;
	localparam logic [2:0] REG_BOX_TOP    = 3'd3;
	localparam logic [2:0] REG_BOX_NEAR   = 3'd4;
	localparam logic [2:0] REG_BOX_FAR    = 3'd5;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef struct packed {
		logic              func;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [9:0]        vertex_index;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [1:0]        status;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXT,
		S_DSEL,
		S_DPREP,
		S_DIV,
		S_DFIN,
		S_CHK,
		S_PREP,
		S_AGEN,
		S_MLO,
		S_MHI,
		S_FIN1,
		S_FIN2
	} fsm_t;

endpackage

`default_nettype wire

// ===== src/mesh_uniform_fit_to_box.sv =====
// ----------------------------------------------------------------------------
// mesh_uniform_fit_to_box
// Stores a vertex set, tracks its bounds and returns vertices scaled
// uniformly and centred into a configured target box.
//
// Usage: an item is taken when start is high and busy is low. func selects
// load or read. A load is stored in the cycle it is taken, busy stays low,
// so loads go one per cycle; its result strobes on done in the next cycle.
// A read of an index is worked by one sequencer: a registered store read,
// an index check, then per axis two prepare steps, two partial products on
// one shared 34x25 multiplier and two add/saturate steps; the result
// strobes on done in the first cycle with busy low, so a new item can be
// taken while it strobes. The first read after a load pass first finds
// the largest extent and runs a restoring divider, one quotient bit per
// cycle; when every extent is zero the divider is skipped. A bad index
// returns after the check step. Results show on rsp for the one cycle done
// is high; the receiver cannot stall, so nothing is held. The config channel
// is always ready. Reset clears the count, bounds and scale and sets the box
// to -1.0..+1.0 per axis; the vertex store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_uniform_fit_to_box (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  mufb_pkg::in_item_t    cmd,
	output logic                  done,
	output mufb_pkg::out_item_t   rsp,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [2:0]            cfg_index,
	input  wire  [31:0]           cfg_data
);

	import mufb_pkg::*;

	fsm_t state_q, state_d;

	logic signed [31:0] box_q [6];
	logic signed [31:0] min_q [3];
	logic signed [31:0] max_q [3];
	logic [CNT_W-1:0]   count_q;
	logic               reading_q;
	logic signed [SCALE_W-1:0] fit_scale_q;

	logic [3*COORD_W-1:0] mem [MAX_VERTICES];
	logic [3*COORD_W-1:0] rd_q;
	logic [IDX_W-1:0]     idx_q;

	logic [31:0]        ext_q [3];
	logic [31:0]        d_q;
	logic signed [32:0] t_q;
	logic               t_neg_q;
	logic [DIVN_W-1:0]  div_num_q;
	logic [31:0]        rem_q;
	logic [DCNT_W-1:0]  dcnt_q;

	logic [1:0]         ax_q;
	logic signed [32:0] d1_q;
	logic signed [32:0] span_q;
	logic signed [32:0] half_q;
	logic signed [33:0] a_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] fit_q;

	logic               done_q;
	out_item_t          rsp_q;

	logic accept, acc_load, acc_read, bad_idx, deg;
	logic [CNT_W-1:0]   eff_count;
	logic signed [31:0] pos [3];
	logic signed [31:0] p_sel, mn_sel, mx_sel, lo_sel, hi_sel;
	logic [1:0]         big_ax;
	logic [32:0]        rem_sh;
	logic               rem_ge;
	logic [32:0]        t_abs;
	logic [63:0]        q_ext;
	logic [SCALE_W-1:0] q_sat;
	logic signed [24:0] mul_b;
	logic signed [58:0] prod;
	logic signed [63:0] sum_out;
	logic signed [31:0] sat_out;

	assign pos[0] = cmd.pos_x;
	assign pos[1] = cmd.pos_y;
	assign pos[2] = cmd.pos_z;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && cmd.func == FUNC_READ) begin
					state_d = reading_q ? S_CHK : S_EXT;
				end
			end
			S_EXT:   state_d = S_DSEL;
			S_DSEL:  state_d = S_DPREP;
			S_DPREP: state_d = (d_q == '0) ? S_CHK : S_DIV;
			S_DIV:   state_d = (dcnt_q == '0) ? S_DFIN : S_DIV;
			S_DFIN:  state_d = S_CHK;
			S_CHK:   state_d = bad_idx ? S_IDLE : S_PREP;
			S_PREP:  state_d = S_AGEN;
			S_AGEN:  state_d = S_MLO;
			S_MLO:   state_d = S_MHI;
			S_MHI:   state_d = S_FIN1;
			S_FIN1:  state_d = S_FIN2;
			S_FIN2:  state_d = (ax_q == AX_Z) ? S_IDLE : S_PREP;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and decodes
	always_comb begin
		busy      = (state_q != S_IDLE);
		cfg_ready = 1'b1;
		done      = done_q;
		rsp       = rsp_q;
		accept    = start && !busy;
		acc_load  = accept && cmd.func == FUNC_LOAD;
		acc_read  = accept && cmd.func == FUNC_READ;
		eff_count = reading_q ? '0 : count_q;
		bad_idx   = {{(CNT_W-IDX_W){1'b0}}, idx_q} >= count_q;
		deg       = (min_q[0] == max_q[0]) && (min_q[1] == max_q[1]) &&
			(min_q[2] == max_q[2]);
	end

	// axis selection
	always_comb begin
		case (ax_q)
			AX_X: begin
				p_sel = rd_q[COORD_W-1:0];
				mn_sel = min_q[0]; mx_sel = max_q[0];
				lo_sel = box_q[REG_BOX_LEFT]; hi_sel = box_q[REG_BOX_RIGHT];
			end
			AX_Y: begin
				p_sel = rd_q[2*COORD_W-1:COORD_W];
				mn_sel = min_q[1]; mx_sel = max_q[1];
				lo_sel = box_q[REG_BOX_BOTTOM]; hi_sel = box_q[REG_BOX_TOP];
			end
			default: begin
				p_sel = rd_q[3*COORD_W-1:2*COORD_W];
				mn_sel = min_q[2]; mx_sel = max_q[2];
				lo_sel = box_q[REG_BOX_NEAR]; hi_sel = box_q[REG_BOX_FAR];
			end
		endcase
	end

	// largest extent, first axis wins a tie
	always_comb begin
		big_ax = AX_X;
		if (ext_q[1] > ext_q[0]) begin
			big_ax = AX_Y;
		end
		if (ext_q[2] > ((big_ax == AX_Y) ? ext_q[1] : ext_q[0])) begin
			big_ax = AX_Z;
		end
	end

	// shared datapath terms
	always_comb begin
		rem_sh  = {rem_q, div_num_q[DIVN_W-1]};
		rem_ge  = rem_sh >= {1'b0, d_q};
		t_abs   = t_q[32] ? 33'(-t_q) : 33'(t_q);
		q_ext   = 64'(div_num_q);
		q_sat   = (q_ext > SCALE_MAX) ? SCALE_W'(SCALE_MAX) : q_ext[SCALE_W-1:0];
		mul_b   = (state_q == S_MHI) ?
			$signed({fit_scale_q[SCALE_W-1], fit_scale_q[SCALE_W-1:SPLIT]}) :
			$signed({1'b0, fit_scale_q[SPLIT-1:0]});
		prod    = a_q * mul_b;
		sum_out = 64'(lo_sel) + (fit_q >>> (FRAC_BITS + 1));
		if (sum_out > 64'sd2147483647) begin
			sat_out = 32'sh7FFF_FFFF;
		end else if (sum_out < -64'sd2147483648) begin
			sat_out = 32'sh8000_0000;
		end else begin
			sat_out = sum_out[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			box_q[0]    <= -32'sd65536;
			box_q[1]    <= 32'sd65536;
			box_q[2]    <= -32'sd65536;
			box_q[3]    <= 32'sd65536;
			box_q[4]    <= -32'sd65536;
			box_q[5]    <= 32'sd65536;
			min_q[0]    <= '0; min_q[1] <= '0; min_q[2] <= '0;
			max_q[0]    <= '0; max_q[1] <= '0; max_q[2] <= '0;
			count_q     <= '0;
			reading_q   <= 1'b0;
			fit_scale_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= acc_load || (state_q == S_CHK && bad_idx) ||
				(state_q == S_FIN2 && ax_q == AX_Z);

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BOX_LEFT:   box_q[0] <= cfg_data;
					REG_BOX_RIGHT:  box_q[1] <= cfg_data;
					REG_BOX_BOTTOM: box_q[2] <= cfg_data;
					REG_BOX_TOP:    box_q[3] <= cfg_data;
					REG_BOX_NEAR:   box_q[4] <= cfg_data;
					REG_BOX_FAR:    box_q[5] <= cfg_data;
					default: ;
				endcase
			end

			if (acc_load) begin
				reading_q <= 1'b0;
				if (eff_count >= CNT_W'(MAX_VERTICES)) begin
					count_q <= eff_count;
				end else begin
					count_q <= eff_count + 1'b1;
					for (int i = 0; i < 3; i++) begin
						if (eff_count == '0 || pos[i] < min_q[i]) begin
							min_q[i] <= pos[i];
						end
						if (eff_count == '0 || pos[i] > max_q[i]) begin
							max_q[i] <= pos[i];
						end
					end
				end
			end

			if (acc_read) begin
				reading_q <= 1'b1;
			end

			if (state_q == S_DPREP && d_q == '0) begin
				fit_scale_q <= '0;
			end
			if (state_q == S_DFIN) begin
				fit_scale_q <= t_neg_q ? -$signed(q_sat) : $signed(q_sat);
			end
		end
	end

	// result item register
	always_ff @(posedge clk) begin
		if (acc_load) begin
			rsp_q <= {{(3*COORD_W){1'b0}},
				(eff_count >= CNT_W'(MAX_VERTICES)) ? ST_FULL : ST_OK};
		end
		if (state_q == S_CHK && bad_idx) begin
			rsp_q <= {{(3*COORD_W){1'b0}}, ST_BAD_INDEX};
		end
		if (state_q == S_FIN2) begin
			case (ax_q)
				AX_X:    rsp_q.out_x <= sat_out;
				AX_Y:    rsp_q.out_y <= sat_out;
				default: begin
					rsp_q <= {rsp_q.out_x, rsp_q.out_y, sat_out,
						deg ? ST_DEGENERATE : ST_OK};
				end
			endcase
		end
	end

	// vertex store
	always_ff @(posedge clk) begin
		if (acc_load && eff_count < CNT_W'(MAX_VERTICES)) begin
			mem[eff_count[IDX_W-1:0]] <= {cmd.pos_z, cmd.pos_y, cmd.pos_x};
		end
		if (acc_read) begin
			rd_q <= mem[cmd.vertex_index[IDX_W-1:0]];
		end
	end

	// scale divider and per-axis sequencer datapath
	always_ff @(posedge clk) begin
		if (acc_read) begin
			idx_q <= cmd.vertex_index[IDX_W-1:0];
		end
		case (state_q)
			S_EXT: begin
				for (int i = 0; i < 3; i++) begin
					ext_q[i] <= 32'(max_q[i] - min_q[i]);
				end
			end
			S_DSEL: begin
				case (big_ax)
					AX_X: begin
						d_q <= ext_q[0];
						t_q <= 33'(box_q[REG_BOX_RIGHT]) - 33'(box_q[REG_BOX_LEFT]);
					end
					AX_Y: begin
						d_q <= ext_q[1];
						t_q <= 33'(box_q[REG_BOX_TOP]) - 33'(box_q[REG_BOX_BOTTOM]);
					end
					default: begin
						d_q <= ext_q[2];
						t_q <= 33'(box_q[REG_BOX_FAR]) - 33'(box_q[REG_BOX_NEAR]);
					end
				endcase
			end
			S_DPREP: begin
				t_neg_q   <= t_q[32];
				div_num_q <= {t_abs[31:0], {FRAC_BITS{1'b0}}};
				rem_q     <= '0;
				dcnt_q    <= DCNT_W'(DIVN_W - 1);
			end
			S_DIV: begin
				rem_q     <= rem_ge ? 32'(rem_sh - {1'b0, d_q}) : rem_sh[31:0];
				div_num_q <= {div_num_q[DIVN_W-2:0], rem_ge};
				dcnt_q    <= dcnt_q - 1'b1;
			end
			S_CHK: begin
				ax_q <= AX_X;
			end
			S_PREP: begin
				d1_q   <= 33'(p_sel) - 33'(mn_sel);
				span_q <= 33'(mx_sel) - 33'(mn_sel);
				half_q <= 33'(hi_sel) - 33'(lo_sel);
			end
			S_AGEN: begin
				a_q <= (34'(d1_q) <<< 1) - 34'(span_q);
			end
			S_MLO: begin
				acc_q <= 64'(prod);
			end
			S_MHI: begin
				acc_q <= acc_q + (64'(prod) <<< SPLIT);
			end
			S_FIN1: begin
				fit_q <= (64'(half_q) <<< FRAC_BITS) + acc_q;
			end
			S_FIN2: begin
				ax_q <= ax_q + 1'b1;
			end
			default: ;
		endcase
	end

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.func == FUNC_READ) |=> (busy && reading_q))
		else $error("read item did not start sequencer");

	a_load_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.func == FUNC_LOAD) |=> (done && !reading_q))
		else $error("load item did not return or leave read phase");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_BAD_INDEX) |->
		(rsp.out_x == 0 && rsp.out_y == 0 && rsp.out_z == 0))
		else $error("bad index item with nonzero coordinates");

endmodule

`default_nettype wire

// ===== sim/tb_mesh_uniform_fit_to_box.sv =====
// ----------------------------------------------------------------------------
// tb_mesh_uniform_fit_to_box
// Self-checking bench for the uniform fit-to-box block. A queue of load and
// read items feeds a clocked driver that predicts every accepted item with a
// local copy of the bounds, scale, store and box registers. A clocked monitor
// checks each strobed result against the oldest prediction. Directed corner
// sets come first, then random vertex sets, one full store and several box
// settings written between phases, under three sender idle rates.
// ----------------------------------------------------------------------------
module tb_mesh_uniform_fit_to_box;

	timeunit 1ns;
	timeprecision 1ps;

	import mufb_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int ROUNDS       = 30;
	localparam int FULL_ROUND   = 12;

	localparam int SPREAD_WIDE = 0;
	localparam int SPREAD_NEAR = 1;
	localparam int SPREAD_EDGE = 2;
	localparam int SPREAD_FLAT = 3;

	localparam logic signed [31:0] C_MIN = 32'h8000_0000;
	localparam logic signed [31:0] C_MAX = 32'h7FFF_FFFF;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam longint S32_MAX = 64'sd2147483647;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	in_item_t    cmd       = '0;
	logic        done;
	out_item_t   rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_BOX_LEFT;
	logic [31:0] cfg_data  = '0;

	// fit model state
	longint             box_lo [3];
	longint             box_hi [3];
	logic signed [31:0] vtx [3][MAX_VERTICES];
	int unsigned        n_stored;
	longint             bmin [3];
	longint             bmax [3];
	longint             fit_scale_q;
	bit                 reading;

	in_item_t  pending [$];
	out_item_t fits_due [$];
	int        cmds_open;
	int        send_idle_pct;
	int        bad_count;
	int        cycle_count = 0;
	int        gen_count;
	bit        gen_reading;

	mesh_uniform_fit_to_box u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [2:0] box_reg(int i);
		case (i)
		0: return REG_BOX_LEFT;
		1: return REG_BOX_RIGHT;
		2: return REG_BOX_BOTTOM;
		3: return REG_BOX_TOP;
		4: return REG_BOX_NEAR;
		default: return REG_BOX_FAR;
		endcase
	endfunction

	function automatic void note_box_write(logic [2:0] idx, logic signed [31:0] v);
		case (idx)
		REG_BOX_LEFT:   box_lo[0] = v;
		REG_BOX_RIGHT:  box_hi[0] = v;
		REG_BOX_BOTTOM: box_lo[1] = v;
		REG_BOX_TOP:    box_hi[1] = v;
		REG_BOX_NEAR:   box_lo[2] = v;
		REG_BOX_FAR:    box_hi[2] = v;
		default: ;
		endcase
	endfunction

	// largest extent, first axis wins a tie
	function automatic longint widest(output int ax);
		longint d;
		int k;
		d = bmax[0] - bmin[0];
		ax = 0;
		for (k = 1; k < 3; k++) begin
			if (bmax[k] - bmin[k] > d) begin
				d = bmax[k] - bmin[k];
				ax = k;
			end
		end
		return d;
	endfunction

	function automatic void fix_scale();
		int ax;
		longint d, t;
		longint unsigned mag, dm, q;
		d = widest(ax);
		if (d <= 0) begin
			fit_scale_q = 0;
			return;
		end
		t = box_hi[ax] - box_lo[ax];
		mag = (t < 0) ? -t : t;
		dm = d;
		q = (mag << FRAC_BITS) / dm;
		if (q > SCALE_MAX)
			q = SCALE_MAX;
		fit_scale_q = (t < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [31:0] fit_coord(longint p, longint mn, longint mx,
			longint lo, longint hi);
		longint a, num, v;
		a = 2 * (p - mn) - (mx - mn);
		num = ((hi - lo) <<< FRAC_BITS) + a * fit_scale_q;
		v = lo + (num >>> (FRAC_BITS + 1));
		if (v > S32_MAX)
			v = S32_MAX;
		if (v < S32_MIN)
			v = S32_MIN;
		return v[31:0];
	endfunction

	function automatic out_item_t fit_step(in_item_t c);
		out_item_t r;
		longint p [3];
		int ax;
		int unsigned k;
		r = '0;
		p[0] = c.pos_x;
		p[1] = c.pos_y;
		p[2] = c.pos_z;
		if (c.func == FUNC_LOAD) begin
			if (reading) begin
				reading = 1'b0;
				n_stored = 0;
			end
			if (n_stored >= MAX_VERTICES) begin
				r.status = ST_FULL;
				return r;
			end
			for (ax = 0; ax < 3; ax++) begin
				if (n_stored == 0 || p[ax] < bmin[ax])
					bmin[ax] = p[ax];
				if (n_stored == 0 || p[ax] > bmax[ax])
					bmax[ax] = p[ax];
				vtx[ax][n_stored] = p[ax][31:0];
			end
			n_stored++;
			r.status = ST_OK;
			return r;
		end
		if (!reading) begin
			fix_scale();
			reading = 1'b1;
		end
		k = c.vertex_index;
		if (k >= n_stored) begin
			r.status = ST_BAD_INDEX;
			return r;
		end
		r.out_x = fit_coord(vtx[0][k], bmin[0], bmax[0], box_lo[0], box_hi[0]);
		r.out_y = fit_coord(vtx[1][k], bmin[1], bmax[1], box_lo[1], box_hi[1]);
		r.out_z = fit_coord(vtx[2][k], bmin[2], bmax[2], box_lo[2], box_hi[2]);
		r.status = (widest(ax) == 0) ? ST_DEGENERATE : ST_OK;
		return r;
	endfunction

	function automatic in_item_t load_item(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		in_item_t c;
		c.func = FUNC_LOAD;
		c.pos_x = x;
		c.pos_y = y;
		c.pos_z = z;
		c.vertex_index = 10'($urandom);
		return c;
	endfunction

	function automatic in_item_t read_item(int unsigned k);
		in_item_t c;
		c.func = FUNC_READ;
		c.pos_x = $urandom;
		c.pos_y = $urandom;
		c.pos_z = $urandom;
		c.vertex_index = 10'(k);
		return c;
	endfunction

	function automatic int unsigned pick_index(int n);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (n == 0 || r < 10)
			return $urandom_range(0, 1023);
		if (r < 15 && n < MAX_VERTICES)
			return n;
		return $urandom_range(0, n - 1);
	endfunction

	function automatic logic signed [31:0] pick_coord(int spread, logic signed [31:0] base);
		case (spread)
		SPREAD_WIDE: return $urandom;
		SPREAD_NEAR: return base + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		SPREAD_EDGE: begin
			case ($urandom_range(0, 4))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			3: return -1;
			default: return base;
			endcase
		end
		default: return base;
		endcase
	endfunction

	// tracks the set size the block will see, for index picks
	task automatic push_cmd(input in_item_t c);
		pending = {pending, c};
		cmds_open++;
		if (c.func == FUNC_LOAD) begin
			if (gen_reading) begin
				gen_count = 0;
				gen_reading = 1'b0;
			end
			if (gen_count < MAX_VERTICES)
				gen_count++;
		end else begin
			gen_reading = 1'b1;
		end
	endtask

	task automatic wait_idle();
		while (cmds_open != 0 || fits_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_box(input int kind);
		logic signed [31:0] b [6];
		logic signed [31:0] u;
		int i;
		for (i = 0; i < 6; i += 2) begin
			case (kind)
			0: begin
				b[i] = C_MIN;
				b[i + 1] = C_MAX;
			end
			1: begin
				b[i] = C_MAX;
				b[i + 1] = C_MIN;
			end
			2: begin
				b[i] = '0;
				b[i + 1] = '0;
			end
			3: begin
				b[i] = 32'sh0001_0000;
				b[i + 1] = -32'sh0001_0000;
			end
			4: begin
				b[i] = $urandom;
				b[i + 1] = $urandom;
			end
			default: begin
				u = $urandom_range(0, 32'h0020_0000);
				b[i] = u - 32'sh0010_0000;
				b[i + 1] = b[i] + $urandom_range(0, 32'h0008_0000);
			end
			endcase
		end
		i = 0;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= box_reg(0);
		cfg_data <= b[0];
		while (i < 6) begin
			@(posedge clk);
			if (cfg_ready) begin
				note_box_write(box_reg(i), b[i]);
				i++;
				if (i < 6) begin
					cfg_index <= box_reg(i);
					cfg_data <= b[i];
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_cmd
		logic took;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			took = start && !busy;
			if (took) begin
				fits_due = {fits_due, fit_step(cmd)};
				cmds_open--;
			end
			if (!start || took) begin
				if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cmd <= pending.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_fit
		out_item_t want;
		if (arst_n && done === 1'b1) begin
			if (fits_due.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected result x=%0d y=%0d z=%0d st=%0d",
						rsp.out_x, rsp.out_y, rsp.out_z, rsp.status);
			end else begin
				want = fits_due.pop_front();
				if (rsp.out_x !== want.out_x || rsp.out_y !== want.out_y ||
						rsp.out_z !== want.out_z || rsp.status !== want.status) begin
					bad_count++;
					if (bad_count <= 10)
						$display("fit mismatch: expected x=%0d y=%0d z=%0d st=%0d, got x=%0d y=%0d z=%0d st=%0d",
							want.out_x, want.out_y, want.out_z, want.status,
							rsp.out_x, rsp.out_y, rsp.out_z, rsp.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_mesh_uniform_fit_to_box NOT OK");
			$finish;
		end
	end

	initial begin
		int r, s, i, ax, k, n_ld, n_rd, split, cfg_no;
		int sty [3];
		bit flat;
		logic signed [31:0] base [3];
		logic signed [31:0] crd [3];
		box_lo = '{-65536, -65536, -65536};
		box_hi = '{65536, 65536, 65536};
		bmin = '{0, 0, 0};
		bmax = '{0, 0, 0};
		n_stored = 0;
		fit_scale_q = 0;
		reading = 1'b0;
		gen_count = 0;
		gen_reading = 1'b0;
		cmds_open = 0;
		bad_count = 0;
		cfg_no = 0;
		send_idle_pct = 16;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty set read, then a single vertex
		push_cmd(read_item(0));
		push_cmd(load_item(0, 0, 0));
		push_cmd(read_item(0));
		push_cmd(read_item(1));
		// full-range extents, x and y tie
		push_cmd(load_item(C_MIN, C_MAX, 0));
		push_cmd(load_item(C_MAX, C_MIN, 32'sh0001_0000));
		push_cmd(load_item(0, 0, C_MIN));
		push_cmd(read_item(0));
		push_cmd(read_item(1));
		push_cmd(read_item(2));
		push_cmd(read_item(3));
		push_cmd(read_item(1023));
		// y widest
		push_cmd(load_item(0, 0, 0));
		push_cmd(load_item(32'sh0001_0000, 32'sh0003_0000, 32'sh0002_0000));
		push_cmd(read_item(1));
		push_cmd(read_item(0));
		// z widest, x flat
		push_cmd(load_item(5, 5, -7));
		push_cmd(load_item(5, 9, 9));
		push_cmd(read_item(0));
		push_cmd(read_item(1));
		// three-way tie
		push_cmd(load_item(-32'sh0003_0000, 32'sh0001_0000, 32'sh0002_0000));
		push_cmd(load_item(32'sh0001_0000, -32'sh0003_0000, -32'sh0002_0000));
		push_cmd(read_item(1));
		push_cmd(read_item(0));
		push_cmd(load_item(C_MAX, C_MAX, C_MAX));
		push_cmd(read_item(0));

		for (r = 0; r < ROUNDS; r++) begin
			if (r % 3 == 0) begin
				wait_idle();
				program_box(cfg_no < 6 ? cfg_no : $urandom_range(0, 5));
				cfg_no++;
			end else begin
				while (cmds_open != 0)
					@(posedge clk);
			end
			@(negedge clk);
			if (r == ROUNDS / 3)
				send_idle_pct = 88;
			else if (r == 2 * ROUNDS / 3)
				send_idle_pct = 0;

			// new box under a fixed scale
			if (r % 3 == 0 && gen_reading && gen_count > 0) begin
				for (i = 0; i < 3; i++)
					push_cmd(read_item(pick_index(gen_count)));
			end

			if (r == FULL_ROUND) begin
				base[1] = $urandom;
				for (i = 0; i < MAX_VERTICES + 3; i++)
					push_cmd(load_item(pick_coord(SPREAD_WIDE, 0),
						pick_coord(SPREAD_NEAR, base[1]), pick_coord(SPREAD_EDGE, 0)));
				push_cmd(read_item(MAX_VERTICES - 1));
				push_cmd(read_item(0));
				for (i = 0; i < 6; i++)
					push_cmd(read_item(pick_index(gen_count)));
			end

			for (s = 0; s < 2; s++) begin
				n_ld = $urandom_range(1, 10);
				n_rd = $urandom_range(1, 8);
				split = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n_ld) : 0;
				flat = ($urandom_range(0, 9) == 0);
				for (ax = 0; ax < 3; ax++) begin
					base[ax] = $urandom;
					k = $urandom_range(0, 9);
					sty[ax] = flat ? SPREAD_FLAT : (k < 4) ? SPREAD_WIDE :
						(k < 8) ? SPREAD_NEAR : (k < 9) ? SPREAD_EDGE : SPREAD_FLAT;
				end
				for (i = 0; i < n_ld; i++) begin
					if (split != 0 && i == split)
						push_cmd(read_item(pick_index(gen_count)));
					for (ax = 0; ax < 3; ax++)
						crd[ax] = pick_coord(sty[ax], base[ax]);
					push_cmd(load_item(crd[0], crd[1], crd[2]));
				end
				for (i = 0; i < n_rd; i++)
					push_cmd(read_item(pick_index(gen_count)));
			end
		end

		wait_idle();
		if (bad_count == 0)
			$display("tb_mesh_uniform_fit_to_box OK");
		else
			$display("tb_mesh_uniform_fit_to_box NOT OK");
		$finish;
	end

endmodule
